>>> hdl/ptts_pkg.sv
// Shared types and constants for the pan/tilt tracking stepper.
// Holds the per-axis state record, band thresholds and register indexes.
// No dependencies.
package ptts_pkg;

	// Field widths
	localparam int unsigned ErrW   = 12;
	localparam int unsigned RadW   = 11;
	localparam int unsigned AngleW = 9;
	localparam int unsigned StepW  = 3;
	localparam int unsigned DwellW = 2;
	localparam int unsigned LimW   = 8;
	localparam int unsigned CfgIdxW = 2;

	// Stream payload widths, padded to whole bytes
	localparam int unsigned InDataW  = 40;
	localparam int unsigned OutDataW = 32;

	// Magnitude bands for step selection
	localparam logic [ErrW:0] BandOne   = 13'd150;
	localparam logic [ErrW:0] BandTwo   = 13'd300;
	localparam logic [ErrW:0] BandThree = 13'd400;
	localparam logic [ErrW:0] BandFour  = 13'd500;

	// Step sizes
	localparam logic [StepW-1:0] StepZero  = 3'd0;
	localparam logic [StepW-1:0] StepOne   = 3'd1;
	localparam logic [StepW-1:0] StepTwo   = 3'd2;
	localparam logic [StepW-1:0] StepThree = 3'd3;
	localparam logic [StepW-1:0] StepFour  = 3'd4;

	// Dwell count at which a step of one is released inside the radius
	localparam logic [DwellW-1:0] DwellRelease = 2'd2;

	// Angle saturation bounds
	localparam logic signed [AngleW+1:0] AngleMax = 11'sd255;
	localparam logic signed [AngleW+1:0] AngleMin = -11'sd256;

	// Reset values of the axis state
	localparam logic signed [AngleW-1:0] TiltAngleRst = 9'sd65;
	localparam logic signed [AngleW-1:0] PanAngleRst  = 9'sd60;

	// Reset values of the limit registers
	localparam logic [LimW-1:0] TiltLowRst  = 8'd30;
	localparam logic [LimW-1:0] TiltHighRst = 8'd100;
	localparam logic [LimW-1:0] PanLowRst   = 8'd0;
	localparam logic [LimW-1:0] PanHighRst  = 8'd119;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_TILT_LOW  = 2'd0,
		CFG_TILT_HIGH = 2'd1,
		CFG_PAN_LOW   = 2'd2,
		CFG_PAN_HIGH  = 2'd3
	} cfg_idx_t;

	// State kept for one axis
	typedef struct packed {
		logic signed [AngleW-1:0] angle;
		logic [StepW-1:0]         step;
		logic [DwellW-1:0]        dwell;
	} axis_state_t;

	// Limits for one axis
	typedef struct packed {
		logic [LimW-1:0] low;
		logic [LimW-1:0] high;
	} axis_limits_t;

endpackage

>>> hdl/ptts_axis.sv
// Next-state logic for one axis: step selection with dwell and limited motion.
// Purely combinational; depends on ptts_pkg.
module ptts_axis
	import ptts_pkg::*;
(
	input  axis_state_t         cur,
	input  logic [ErrW-1:0]     err,
	input  logic [RadW-1:0]     radius,
	input  axis_limits_t        lim,
	output axis_state_t         nxt
);

	logic [ErrW:0]            mag;
	logic [ErrW:0]            rad_ext;
	logic signed [ErrW:0]     err_s;
	logic signed [ErrW:0]     half_s;
	logic [StepW-1:0]         step_n;
	logic [DwellW-1:0]        dwell_n;
	logic signed [AngleW+1:0] pos;
	logic signed [AngleW+1:0] step_s;
	logic signed [AngleW+1:0] lo_s;
	logic signed [AngleW+1:0] hi_s;
	logic signed [AngleW+1:0] moved;
	logic                     go_down;
	logic                     go_up;

	// Magnitude of the error, one bit wider so the most negative value fits
	always_comb begin
		err_s   = signed'({err[ErrW-1], err});
		mag     = err[ErrW-1] ? (13'd0 - unsigned'(err_s)) : unsigned'(err_s);
		rad_ext = {2'b00, radius};
		half_s  = signed'({3'b000, radius[RadW-1:1]});
	end

	// Step selection; the gap band between the third and fourth threshold holds
	always_comb begin
		step_n  = cur.step;
		dwell_n = cur.dwell;
		priority if (mag <= rad_ext) begin
			if (cur.dwell >= DwellRelease) begin
				step_n  = StepOne;
				dwell_n = '0;
			end else begin
				step_n  = StepZero;
				dwell_n = cur.dwell + 2'd1;
			end
		end else if (mag <= BandOne) begin
			step_n  = StepOne;
			dwell_n = '0;
		end else if (mag <= BandTwo) begin
			step_n  = StepTwo;
			dwell_n = '0;
		end else if (mag <= BandThree) begin
			step_n  = StepThree;
			dwell_n = '0;
		end else if (mag > BandFour) begin
			step_n  = StepFour;
			dwell_n = '0;
		end
	end

	// Motion toward the target when the neighboring degree is within the limit
	always_comb begin
		pos     = signed'({{2{cur.angle[AngleW-1]}}, cur.angle});
		step_s  = signed'({8'd0, step_n});
		lo_s    = signed'({3'b000, lim.low});
		hi_s    = signed'({3'b000, lim.high});
		go_down = (err_s < -half_s) && ((pos - 11'sd1) >= lo_s);
		go_up   = (err_s > half_s) && ((pos + 11'sd1) <= hi_s);
		moved   = pos;
		if (go_down) begin
			moved = pos - step_s;
		end else if (go_up) begin
			moved = pos + step_s;
		end
		if (moved > AngleMax) begin
			moved = AngleMax;
		end else if (moved < AngleMin) begin
			moved = AngleMin;
		end
	end

	assign nxt.angle = moved[AngleW-1:0];
	assign nxt.step  = step_n;
	assign nxt.dwell = dwell_n;

endmodule

>>> hdl/pan_tilt_tracking_stepper_core.sv
// Top level of the pan/tilt tracking stepper: stream ports, limit registers,
// axis state and the input and result registers. Depends on ptts_pkg, ptts_axis.
//
//  channel  direction  payload                                          handshake
//  s_*      in         tilt_error, pan_error, target_radius, fire       tvalid/tready
//  m_*      out        tilt/pan position, tilt/pan step, laser_on       tvalid/tready
//  cfg_*    in         register index, 8-bit limit value                valid/ready
//
// One request per cycle is sustained while results are taken. The axis update sits
// between the input register and the result register and reads and writes the axis
// state in the same cycle. Reset restores the limits and axis state to their
// defaults. When the result is not taken, the input register holds one more
// request, then s_tready drops.
module pan_tilt_tracking_stepper_core
	import ptts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// tilt_error[11:0], pan_error[23:12], target_radius[34:24], fire[35], zero pad
	input  logic [InDataW-1:0]  s_tdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	// tilt_position[8:0], pan_position[17:9], tilt_step_out[20:18],
	// pan_step_out[23:21], laser_on[24], zero pad
	output logic [OutDataW-1:0] m_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [LimW-1:0]     cfg_data
);

	logic                valid_s1;
	logic [ErrW-1:0]     tilt_err_s1;
	logic [ErrW-1:0]     pan_err_s1;
	logic [RadW-1:0]     radius_s1;
	logic                fire_s1;
	logic                advance;
	logic                out_valid_q;
	logic [OutDataW-1:0] out_data_q;
	axis_limits_t        tilt_lim_q;
	axis_limits_t        pan_lim_q;
	axis_state_t         tilt_q;
	axis_state_t         pan_q;
	axis_state_t         tilt_nxt;
	axis_state_t         pan_nxt;
	cfg_idx_t            cfg_sel;

	// Flow control: the update runs when the result register is free or drains
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign cfg_sel   = cfg_idx_t'(cfg_index);

	// Limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_lim_q.low  <= TiltLowRst;
			tilt_lim_q.high <= TiltHighRst;
			pan_lim_q.low   <= PanLowRst;
			pan_lim_q.high  <= PanHighRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_sel)
				CFG_TILT_LOW:  tilt_lim_q.low  <= cfg_data;
				CFG_TILT_HIGH: tilt_lim_q.high <= cfg_data;
				CFG_PAN_LOW:   pan_lim_q.low   <= cfg_data;
				CFG_PAN_HIGH:  pan_lim_q.high  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tilt_err_s1 <= s_tdata[11:0];
			pan_err_s1  <= s_tdata[23:12];
			radius_s1   <= s_tdata[34:24];
			fire_s1     <= s_tdata[35];
		end
	end

	// Per-axis next-state logic
	ptts_axis u_tilt (
		.cur    (tilt_q),
		.err    (tilt_err_s1),
		.radius (radius_s1),
		.lim    (tilt_lim_q),
		.nxt    (tilt_nxt)
	);

	ptts_axis u_pan (
		.cur    (pan_q),
		.err    (pan_err_s1),
		.radius (radius_s1),
		.lim    (pan_lim_q),
		.nxt    (pan_nxt)
	);

	// Axis state, updated once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_q.angle <= TiltAngleRst;
			tilt_q.step  <= StepOne;
			tilt_q.dwell <= '0;
			pan_q.angle  <= PanAngleRst;
			pan_q.step   <= StepOne;
			pan_q.dwell  <= '0;
		end else if (advance) begin
			tilt_q <= tilt_nxt;
			pan_q  <= pan_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {7'd0, fire_s1, pan_nxt.step, tilt_nxt.step,
				pan_nxt.angle, tilt_nxt.angle};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// The dwell counter never passes the release count
	a_dwell_range: assert property (@(posedge clk) disable iff (!arst_n)
		tilt_q.dwell != 2'd3 && pan_q.dwell != 2'd3)
		else $error("dwell counter out of range");

	// A step of zero goes with a running dwell count and only then
	a_step_dwell: assert property (@(posedge clk) disable iff (!arst_n)
		((tilt_q.step == StepZero) == (tilt_q.dwell != 2'd0)) &&
		((pan_q.step == StepZero) == (pan_q.dwell != 2'd0)))
		else $error("step and dwell disagree");

	// Axis state changes only when a request is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(tilt_q) && $stable(pan_q))
		else $error("axis state changed without a request");

	// One request moves an angle by at most the largest step
	a_angle_bound: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=>
		(($signed(tilt_q.angle) - $signed($past(tilt_q.angle)) <= 4) &&
		 ($signed($past(tilt_q.angle)) - $signed(tilt_q.angle) <= 4) &&
		 ($signed(pan_q.angle) - $signed($past(pan_q.angle)) <= 4) &&
		 ($signed($past(pan_q.angle)) - $signed(pan_q.angle) <= 4)))
		else $error("angle moved by more than one step");

endmodule

>>> dv/pan_tilt_tracking_stepper_core_test.sv
// Self-checking bench for pan_tilt_tracking_stepper_core: drives aim requests, predicts
// positions, steps and laser per request and compares every result in order.
// Depends on ptts_pkg and the core RTL only.
module pan_tilt_tracking_stepper_core_test;
	import ptts_pkg::*;

	localparam int PhaseCount  = 8;
	localparam int PhaseItems  = 244;
	localparam int CycleLimit  = 300000;
	localparam int DrainCycles = 8;
	localparam int PrintCap    = 40;

	// Expected result, packed in the same order as m_tdata from bit 0 up.
	typedef struct packed {
		logic       laser;
		logic [2:0] pan_step;
		logic [2:0] tilt_step;
		logic [8:0] pan_pos;
		logic [8:0] tilt_pos;
	} pose_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic [InDataW-1:0]  s_tdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [OutDataW-1:0] m_tdata;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	cfg_idx_t            cfg_index = CFG_TILT_LOW;
	logic [LimW-1:0]     cfg_data = '0;

	// Predicted mount state and limits.
	axis_state_t  tilt_st;
	axis_state_t  pan_st;
	axis_limits_t tilt_lim;
	axis_limits_t pan_lim;

	logic [InDataW-1:0] aim_queue[$];
	pose_t              pose_queue[$];

	bit    steady_send = 1'b0;
	bit    steady_take = 1'b0;
	int    send_gap = 0;
	int    take_wait = 0;
	int    take_draw;
	pose_t got;
	pose_t want;
	int    mismatches = 0;
	int    sent_count = 0;
	int    result_count = 0;
	int    write_count = 0;
	int    top_hits = 0;
	int    step_seen [5];
	int    cycle_count = 0;

	pan_tilt_tracking_stepper_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Prints one line per mismatch, up to a cap, and counts all of them.
	task automatic flag_mismatch(input string what, input logic [31:0] seen,
			input logic [31:0] wanted);
		if (mismatches < PrintCap)
			$display("mismatch on %s: got %0h, expected %0h (result %0d)",
				what, seen, wanted, result_count);
		mismatches++;
	endtask

	// Picks the step from the error band, then moves the axis within its limits.
	function automatic void step_axis(inout axis_state_t st, input int err, input int rad,
			input int lo, input int hi);
		int mag;
		int half;
		int pos;
		mag  = (err < 0) ? -err : err;
		half = rad / 2;
		if (mag <= rad) begin
			if (st.dwell >= DwellRelease) begin
				st.step  = StepOne;
				st.dwell = '0;
			end else begin
				st.dwell = st.dwell + 2'd1;
				st.step  = StepZero;
			end
		end else if (mag <= int'(BandOne)) begin
			st.step  = StepOne;
			st.dwell = '0;
		end else if (mag <= int'(BandTwo)) begin
			st.step  = StepTwo;
			st.dwell = '0;
		end else if (mag <= int'(BandThree)) begin
			st.step  = StepThree;
			st.dwell = '0;
		end else if (mag > int'(BandFour)) begin
			st.step  = StepFour;
			st.dwell = '0;
		end
		// The gap band between the third and fourth thresholds keeps step and dwell.
		pos = int'(st.angle);
		if (err < -half && pos - 1 >= lo)
			pos = pos - int'(st.step);
		if (err > half && pos + 1 <= hi)
			pos = pos + int'(st.step);
		if (pos > int'(AngleMax))
			pos = int'(AngleMax);
		if (pos < int'(AngleMin))
			pos = int'(AngleMin);
		st.angle = pos[AngleW-1:0];
	endfunction

	// Advances both axes for one accepted request and returns the expected result.
	function automatic pose_t advance_mount(input logic [InDataW-1:0] word);
		pose_t p;
		int    te;
		int    pe;
		int    rad;
		te  = int'($signed(word[11:0]));
		pe  = int'($signed(word[23:12]));
		rad = int'(word[34:24]);
		step_axis(tilt_st, te, rad, int'(tilt_lim.low), int'(tilt_lim.high));
		step_axis(pan_st, pe, rad, int'(pan_lim.low), int'(pan_lim.high));
		p.tilt_pos  = tilt_st.angle;
		p.pan_pos   = pan_st.angle;
		p.tilt_step = tilt_st.step;
		p.pan_step  = pan_st.step;
		p.laser     = word[35];
		return p;
	endfunction

	// Error drawn across the step bands, their edges, the radius and the full range.
	function automatic int pick_error(input int rad, input int dir);
		int mag;
		int sgn;
		int raw;
		case ($urandom_range(0, 9))
			0: mag = $urandom_range(0, rad);
			1: mag = $urandom_range(0, 150);
			2: mag = $urandom_range(151, 300);
			3: mag = $urandom_range(301, 400);
			4: mag = $urandom_range(401, 500);
			5: mag = $urandom_range(501, 2048);
			6: begin
				case ($urandom_range(0, 11))
					0: mag = 150;
					1: mag = 151;
					2: mag = 300;
					3: mag = 301;
					4: mag = 400;
					5: mag = 401;
					6: mag = 500;
					7: mag = 501;
					8: mag = rad;
					9: mag = rad + 1;
					10: mag = rad / 2;
					default: mag = rad / 2 + 1;
				endcase
			end
			default: begin
				raw = $urandom_range(0, 4095);
				return (raw >= 2048) ? raw - 4096 : raw;
			end
		endcase
		sgn = ($urandom_range(0, 3) != 0) ? dir : -dir;
		if (sgn > 0 && mag > 2047)
			mag = 2047;
		if (mag > 2048)
			mag = 2048;
		return sgn * mag;
	endfunction

	function automatic void add_request(input int te, input int pe, input int rad,
			input bit fire);
		logic [InDataW-1:0] word;
		word = '0;
		word[11:0]  = te[11:0];
		word[23:12] = pe[11:0];
		word[34:24] = rad[10:0];
		word[35]    = fire;
		aim_queue.push_back(word);
	endfunction

	// Writes one limit register and mirrors it in the predicted limits.
	task automatic write_limit(input cfg_idx_t idx, input logic [LimW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_TILT_LOW:  tilt_lim.low  = val;
			CFG_TILT_HIGH: tilt_lim.high = val;
			CFG_PAN_LOW:   pan_lim.low   = val;
			CFG_PAN_HIGH:  pan_lim.high  = val;
		endcase
		write_count++;
	endtask

	// Waits until every queued request is accepted and every result has come back.
	task automatic drain;
		do @(negedge clk); while (aim_queue.size() != 0 || s_tvalid || pose_queue.size() != 0);
	endtask

	// Request driver: presents queued requests and predicts each one on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				pose_queue.push_back(advance_mount(s_tdata));
				sent_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					s_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (aim_queue.size() > 0) begin
					s_tdata  <= aim_queue.pop_front();
					s_tvalid <= 1'b1;
					send_gap <= steady_send ? 0 : $urandom_range(0, 9);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each result against the oldest prediction, stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			take_wait <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pose_queue.size() == 0) begin
					flag_mismatch("unexpected result", m_tdata, '0);
				end else begin
					want = pose_queue.pop_front();
					got  = pose_t'(m_tdata[24:0]);
					if (got.tilt_pos !== want.tilt_pos)
						flag_mismatch("tilt_position", 32'(got.tilt_pos),
							32'(want.tilt_pos));
					if (got.pan_pos !== want.pan_pos)
						flag_mismatch("pan_position", 32'(got.pan_pos),
							32'(want.pan_pos));
					if (got.tilt_step !== want.tilt_step)
						flag_mismatch("tilt_step_out", 32'(got.tilt_step),
							32'(want.tilt_step));
					if (got.pan_step !== want.pan_step)
						flag_mismatch("pan_step_out", 32'(got.pan_step),
							32'(want.pan_step));
					if (got.laser !== want.laser)
						flag_mismatch("laser_on", 32'(got.laser), 32'(want.laser));
					if (m_tdata[OutDataW-1:25] !== '0)
						flag_mismatch("pad bits", 32'(m_tdata[OutDataW-1:25]), '0);
					step_seen[want.tilt_step]++;
					step_seen[want.pan_step]++;
					if (want.tilt_pos == 9'd255 || want.pan_pos == 9'd255)
						top_hits++;
				end
				result_count++;
				take_draw = steady_take ? 0 : $urandom_range(0, 9);
				take_wait <= take_draw;
				m_tready  <= (take_draw == 0);
			end else if (take_wait > 0) begin
				take_wait <= take_wait - 1;
				m_tready  <= (take_wait == 1);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stimulus: directed requests at reset limits, then random phases under new limits.
	initial begin
		int              ph;
		int              i;
		int              k;
		int              t_dir;
		int              p_dir;
		int              rad;
		logic [LimW-1:0] lims [4];

		tilt_st  = '{angle: TiltAngleRst, step: StepOne, dwell: '0};
		pan_st   = '{angle: PanAngleRst, step: StepOne, dwell: '0};
		tilt_lim = '{low: TiltLowRst, high: TiltHighRst};
		pan_lim  = '{low: PanLowRst, high: PanHighRst};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Dwell inside a zero radius: two zero steps, then a release of one.
		add_request(0, 0, 0, 0);
		add_request(0, 0, 0, 1);
		add_request(0, 0, 0, 0);
		// Band edges on both sides of each threshold, opposite signs per axis.
		add_request(150, -150, 10, 1);
		add_request(151, -151, 10, 0);
		add_request(300, -300, 10, 1);
		add_request(301, -301, 10, 0);
		add_request(400, -400, 10, 1);
		add_request(401, -401, 10, 0);
		add_request(500, -500, 10, 1);
		add_request(501, -501, 10, 0);
		// Error extremes with no radius and with the largest radius.
		add_request(2047, -2048, 0, 1);
		add_request(-2048, 2047, 0, 0);
		add_request(-2048, 2047, 2047, 1);
		// Inside the radius but past its half: moves by the dwell step.
		add_request(80, -80, 100, 0);
		add_request(80, -80, 100, 1);
		add_request(50, -50, 100, 0);
		add_request(51, -51, 101, 1);
		// Gap band right after a dwell and just outside the radius.
		add_request(450, -450, 0, 0);
		add_request(450, 450, 449, 1);
		add_request(-1, 1, 1, 0);
		add_request(2047, 2047, 2046, 1);
		drain();

		for (ph = 0; ph < PhaseCount; ph++) begin
			case (ph)
				0: lims = '{8'd0, 8'd180, 8'd0, 8'd180};
				1: lims = '{8'd90, 8'd90, 8'd180, 8'd0};
				2: lims = '{8'd0, 8'd255, 8'd0, 8'd255};
				3: lims = '{8'd0, 8'd0, 8'd180, 8'd180};
				4: lims = '{8'd45, 8'd135, 8'd20, 8'd160};
				7: lims = '{8'd30, 8'd100, 8'd0, 8'd119};
				default: begin
					for (k = 0; k < 4; k++)
						lims[k] = LimW'($urandom_range(0, 180));
				end
			endcase
			for (k = 0; k < 4; k++)
				write_limit(cfg_idx_t'(k), lims[k]);
			@(negedge clk);
			steady_send = (ph == 1 || ph == 4);
			steady_take = (ph == 3 || ph == 4);
			t_dir = (ph % 2 == 0) ? 1 : -1;
			p_dir = t_dir;
			for (i = 0; i < PhaseItems; i++) begin
				if ($urandom_range(0, 39) == 0)
					t_dir = -t_dir;
				if ($urandom_range(0, 39) == 0)
					p_dir = -p_dir;
				case ($urandom_range(0, 19))
					0: rad = 0;
					1: rad = 2047;
					2, 3: rad = $urandom_range(0, 2047);
					4, 5, 6, 7, 8: rad = $urandom_range(0, 600);
					default: rad = $urandom_range(0, 160);
				endcase
				add_request(pick_error(rad, t_dir), pick_error(rad, p_dir), rad,
					1'($urandom_range(0, 1)));
			end
			drain();
		end

		repeat (DrainCycles) @(posedge clk);
		if (pose_queue.size() != 0)
			flag_mismatch("results never delivered", pose_queue.size(), 0);
		$display("Covered %0d requests and %0d results over %0d limit settings (%0d writes).",
			sent_count, result_count, PhaseCount + 1, write_count);
		$display("Steps seen 0..4: %0d %0d %0d %0d %0d; results at the top angle: %0d.",
			step_seen[0], step_seen[1], step_seen[2], step_seen[3], step_seen[4], top_hits);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/ptts_pkg.sv
hdl/ptts_axis.sv
hdl/pan_tilt_tracking_stepper_core.sv
dv/pan_tilt_tracking_stepper_core_test.sv
